>>> hw/rtl/hdlf_pkg.sv
package hdlf_pkg;

  localparam int unsigned LINE_BYTES = 16;
  localparam int unsigned POS_W      = $clog2(LINE_BYTES);
  localparam int unsigned HALF_POS   = LINE_BYTES / 2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_NL    = 8'h0a;

  // register index decoded from paddr[2]
  localparam logic REG_SKIP  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic [31:0] skip_count;
    logic [31:0] dump_limit;
    logic        skip_load;
    logic [31:0] skip_load_val;
  } cfg_t;

  typedef struct packed {
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [POS_W-1:0] rd_addr;
  } mem_req_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'h0, v};
    end else begin
      r = 8'h57 + {4'h0, v};
    end
    return r;
  endfunction

  function automatic logic [7:0] printable(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'h20 && c <= 8'h7e) begin
      r = c;
    end else begin
      r = CH_DOT;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/hdlf_if.sv
interface hdlf_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source(output valid, action, data_byte, input ready);
  modport sink(input valid, action, data_byte, output ready);
endinterface

interface hdlf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char0;
  logic [7:0] char1;
  logic [7:0] char2;
  logic [7:0] char3;
  logic [2:0] char_count;
  logic       last;

  modport source(output valid, char0, char1, char2, char3, char_count, last, input ready);
  modport sink(input valid, char0, char1, char2, char3, char_count, last, output ready);
endinterface

>>> hw/rtl/hdlf_apb_regs.sv
module hdlf_apb_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output hdlf_pkg::cfg_t      cfg_o
);

  logic [31:0] skip_q, skip_d;
  logic [31:0] limit_q, limit_d;
  logic        wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    skip_d  = skip_q;
    limit_d = limit_q;
    if (wr) begin
      if (paddr[2] == hdlf_pkg::REG_SKIP) begin
        skip_d = pwdata;
      end else begin
        limit_d = pwdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q  <= '0;
      limit_q <= '0;
    end else begin
      skip_q  <= skip_d;
      limit_q <= limit_d;
    end
  end

  assign prdata = (paddr[2] == hdlf_pkg::REG_SKIP) ? skip_q : limit_q;

  assign cfg_o.skip_count    = skip_q;
  assign cfg_o.dump_limit    = limit_q;
  assign cfg_o.skip_load     = wr && (paddr[2] == hdlf_pkg::REG_SKIP);
  assign cfg_o.skip_load_val = pwdata;

endmodule

>>> hw/rtl/hdlf_line_mem.sv
module hdlf_line_mem (
  input  logic                 clk_i,
  input  hdlf_pkg::mem_req_t   req_i,
  output logic [7:0]           rd_data_o
);

  logic [7:0] mem [hdlf_pkg::LINE_BYTES];
  logic [7:0] rd_q;

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> hw/rtl/hdlf_fmt.sv
module hdlf_fmt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hdlf_pkg::cfg_t      cfg_i,
  hdlf_in_if.sink             in_i,
  hdlf_out_if.source          out_o,
  output hdlf_pkg::mem_req_t  mem_req_o,
  input  logic [7:0]          mem_rd_i
);

  localparam int unsigned PW = hdlf_pkg::POS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_CELL,
    ST_TRL_OPEN,
    ST_TRL_BODY,
    ST_TRL_CLOSE
  } st_e;

  st_e         st_q, st_d;
  logic [3:0]  idx_q, idx_d;
  logic [PW-1:0] pos_q, pos_d;
  logic        pad_q, pad_d;
  logic        trl_q, trl_d;
  logic [PW:0] blank_q, blank_d;
  logic [7:0]  byte_q, byte_d;
  logic [31:0] addr_q, addr_d;

  logic [PW-1:0] line_pos_q, line_pos_d;
  logic [31:0] addr_cnt_q, addr_cnt_d;
  logic [31:0] skipped_q, skipped_d;
  logic [31:0] dumped_q, dumped_d;

  logic [7:0]  pk_q [3];
  logic [7:0]  pk_d [3];
  logic [1:0]  pk_cnt_q, pk_cnt_d;

  logic        o_valid_q, o_valid_d;
  logic [7:0]  o_ch_q [4];
  logic [7:0]  o_ch_d [4];
  logic [2:0]  o_cnt_q, o_cnt_d;
  logic        o_last_q, o_last_d;

  logic        active, fin, emit, out_free, adv, cell_end, half;
  logic [3:0]  lead;
  logic [3:0]  nib;
  logic [7:0]  ch;
  logic        accept;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (st_q == ST_IDLE);

  always_comb begin
    ch       = hdlf_pkg::CH_SPACE;
    fin      = 1'b0;
    cell_end = 1'b0;
    half     = (pos_q == PW'(hdlf_pkg::HALF_POS));
    lead     = half ? 4'd2 : 4'd1;
    nib      = 4'(addr_q >> {~idx_q[2:0], 2'b00});
    case (st_q)
      ST_HDR: begin
        if (idx_q < 4'd8) begin
          ch = hdlf_pkg::hex_digit(nib);
        end
      end
      ST_CELL: begin
        cell_end = (idx_q == (half ? 4'd3 : 4'd2));
        if (!pad_q && idx_q >= lead) begin
          ch = hdlf_pkg::hex_digit((idx_q == lead) ? byte_q[7:4] : byte_q[3:0]);
        end
        fin = cell_end && !pad_q && !trl_q;
      end
      ST_TRL_OPEN: begin
        if (idx_q == 4'd2) begin
          ch = hdlf_pkg::CH_BAR;
        end
      end
      ST_TRL_BODY: begin
        // padded positions show blanks
        if ({1'b0, idx_q[PW-1:0]} < blank_q) begin
          ch = hdlf_pkg::printable(mem_rd_i);
        end
      end
      ST_TRL_CLOSE: begin
        ch  = (idx_q == 4'd0) ? hdlf_pkg::CH_BAR : hdlf_pkg::CH_NL;
        fin = (idx_q == 4'd1);
      end
      default: begin
        ch = hdlf_pkg::CH_SPACE;
      end
    endcase
  end

  assign active   = (st_q != ST_IDLE);
  assign emit     = active && (pk_cnt_q == 2'd3 || fin);
  assign out_free = !o_valid_q || out_o.ready;
  assign adv      = active && (!emit || out_free);

  always_comb begin
    st_d       = st_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    pad_d      = pad_q;
    trl_d      = trl_q;
    blank_d    = blank_q;
    byte_d     = byte_q;
    addr_d     = addr_q;
    line_pos_d = line_pos_q;
    addr_cnt_d = addr_cnt_q;
    skipped_d  = skipped_q;
    dumped_d   = dumped_q;
    pk_d       = pk_q;
    pk_cnt_d   = pk_cnt_q;
    o_valid_d  = o_valid_q;
    o_ch_d     = o_ch_q;
    o_cnt_d    = o_cnt_q;
    o_last_d   = o_last_q;

    mem_req_o.wr_en   = 1'b0;
    mem_req_o.wr_addr = line_pos_q;
    mem_req_o.wr_data = in_i.data_byte;
    mem_req_o.rd_en   = 1'b0;
    mem_req_o.rd_addr = (st_q == ST_TRL_OPEN) ? '0 : idx_q[PW-1:0] + PW'(1);

    if (cfg_i.skip_load) begin
      addr_cnt_d = cfg_i.skip_load_val;
    end

    if (accept) begin
      if (in_i.action) begin
        if (line_pos_q != '0) begin
          st_d    = ST_CELL;
          idx_d   = '0;
          pos_d   = line_pos_q;
          pad_d   = 1'b1;
          trl_d   = 1'b1;
          blank_d = {1'b0, line_pos_q};
        end
        line_pos_d = '0;
        skipped_d  = '0;
        dumped_d   = '0;
        addr_cnt_d = cfg_i.skip_count;
      end else if (skipped_q < cfg_i.skip_count) begin
        skipped_d = skipped_q + 32'd1;
      end else if (cfg_i.dump_limit == '0 || dumped_q < cfg_i.dump_limit) begin
        mem_req_o.wr_en = 1'b1;
        st_d       = (line_pos_q == '0) ? ST_HDR : ST_CELL;
        idx_d      = '0;
        pos_d      = line_pos_q;
        pad_d      = 1'b0;
        trl_d      = (line_pos_q == PW'(hdlf_pkg::LINE_BYTES - 1));
        blank_d    = (PW + 1)'(hdlf_pkg::LINE_BYTES);
        byte_d     = in_i.data_byte;
        addr_d     = addr_cnt_q;
        line_pos_d = line_pos_q + PW'(1);
        addr_cnt_d = addr_cnt_q + 32'd1;
        if (dumped_q != '1) begin
          dumped_d = dumped_q + 32'd1;
        end
      end
    end

    if (o_valid_q && out_o.ready) begin
      o_valid_d = 1'b0;
    end

    if (adv) begin
      // pack the character
      if (emit) begin
        o_valid_d = 1'b1;
        for (int j = 0; j < 3; j++) begin
          if (2'(j) < pk_cnt_q) begin
            o_ch_d[j] = pk_q[j];
          end else if (2'(j) == pk_cnt_q) begin
            o_ch_d[j] = ch;
          end else begin
            o_ch_d[j] = 8'h00;
          end
        end
        o_ch_d[3] = (pk_cnt_q == 2'd3) ? ch : 8'h00;
        o_cnt_d   = {1'b0, pk_cnt_q} + 3'd1;
        o_last_d  = fin;
        pk_cnt_d  = '0;
      end else begin
        pk_d[pk_cnt_q] = ch;
        pk_cnt_d       = pk_cnt_q + 2'd1;
      end

      // step the sequencer
      case (st_q)
        ST_HDR: begin
          if (idx_q == 4'd8) begin
            st_d  = ST_CELL;
            idx_d = '0;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        ST_CELL: begin
          if (cell_end) begin
            idx_d = '0;
            if (pad_q && pos_q != PW'(hdlf_pkg::LINE_BYTES - 1)) begin
              pos_d = pos_q + PW'(1);
            end else if (trl_q) begin
              st_d = ST_TRL_OPEN;
            end else begin
              st_d = ST_IDLE;
            end
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        ST_TRL_OPEN: begin
          if (idx_q == 4'd2) begin
            mem_req_o.rd_en = 1'b1;
            st_d  = ST_TRL_BODY;
            idx_d = '0;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        ST_TRL_BODY: begin
          if (idx_q == 4'(hdlf_pkg::LINE_BYTES - 1)) begin
            st_d  = ST_TRL_CLOSE;
            idx_d = '0;
          end else begin
            mem_req_o.rd_en = 1'b1;
            idx_d = idx_q + 4'd1;
          end
        end
        ST_TRL_CLOSE: begin
          if (idx_q == 4'd1) begin
            st_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        default: begin
          st_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      idx_q      <= '0;
      pos_q      <= '0;
      pad_q      <= 1'b0;
      trl_q      <= 1'b0;
      blank_q    <= '0;
      line_pos_q <= '0;
      addr_cnt_q <= '0;
      skipped_q  <= '0;
      dumped_q   <= '0;
      pk_cnt_q   <= '0;
      o_valid_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      idx_q      <= idx_d;
      pos_q      <= pos_d;
      pad_q      <= pad_d;
      trl_q      <= trl_d;
      blank_q    <= blank_d;
      line_pos_q <= line_pos_d;
      addr_cnt_q <= addr_cnt_d;
      skipped_q  <= skipped_d;
      dumped_q   <= dumped_d;
      pk_cnt_q   <= pk_cnt_d;
      o_valid_q  <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    addr_q   <= addr_d;
    pk_q     <= pk_d;
    o_ch_q   <= o_ch_d;
    o_cnt_q  <= o_cnt_d;
    o_last_q <= o_last_d;
  end

  assign out_o.valid      = o_valid_q;
  assign out_o.char0      = o_ch_q[0];
  assign out_o.char1      = o_ch_q[1];
  assign out_o.char2      = o_ch_q[2];
  assign out_o.char3      = o_ch_q[3];
  assign out_o.char_count = o_cnt_q;
  assign out_o.last       = o_last_q;

  a_idle_packer_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> (pk_cnt_q == 2'd0))
    else $error("packer holds characters while idle");

  a_out_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q |-> (o_cnt_q != 3'd0 && o_cnt_q <= 3'd4))
    else $error("result character count out of range");

  a_read_in_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.rd_en |-> (st_q == ST_TRL_OPEN || st_q == ST_TRL_BODY))
    else $error("line memory read outside trailer");

  a_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> (accept && st_q == ST_IDLE && !in_i.action))
    else $error("line memory write without a data request");

  a_short_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_cnt_q != 3'd4) |-> o_last_q)
    else $error("short result that is not the last");

endmodule

>>> hw/rtl/hex_dump_line_formatter.sv
// output: characters are packed four to a word; a word is registered once the packer holds
//   four characters or at the last character of the request
// throughput: one character a cycle while the output is not stalled; the next request is
//   taken the cycle after the last character; a request makes 3 characters for a mid-line
//   byte (4 at the half), 12 with a line header, 24 with a trailer; one with no text keeps it idle
// reset: async active low; clears config, counters, sequencer; keeps line memory and data
module hex_dump_line_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  hdlf_in_if.sink     in_i,
  hdlf_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hdlf_pkg::cfg_t     cfg;
  hdlf_pkg::mem_req_t mem_req;
  logic [7:0]         mem_rd;

  hdlf_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hdlf_line_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rd)
  );

  hdlf_fmt u_fmt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_i      (in_i),
    .out_o     (out_o),
    .mem_req_o (mem_req),
    .mem_rd_i  (mem_rd)
  );

endmodule

>>> sim/hex_dump_line_formatter_tb.sv
module hex_dump_line_formatter_tb;

  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TOTAL_ITEMS  = 480;

  localparam logic [2:0] ADDR_SKIP  = {hdlf_pkg::REG_SKIP, 2'b00};
  localparam logic [2:0] ADDR_LIMIT = {hdlf_pkg::REG_LIMIT, 2'b00};

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
    logic [2:0] count;
    logic       last;
  } text_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hdlf_in_if  in_bus();
  hdlf_out_if out_bus();

  hex_dump_line_formatter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // formatter state as the block should hold it
  logic [31:0] fmt_skip;
  logic [31:0] fmt_limit;
  logic [31:0] fmt_addr;
  logic [31:0] fmt_skipped;
  logic [31:0] fmt_dumped;
  logic [7:0]  fmt_line [hdlf_pkg::LINE_BYTES];
  int unsigned fmt_pos;

  logic [7:0] step_text [$];
  text_word_t text_expected [$];

  int unsigned text_errors;
  int unsigned words_checked;
  int unsigned requests_sent;
  int unsigned text_requests;
  int unsigned reg_writes;
  int unsigned holds_done;
  int unsigned burst_left;
  bit          hold_request;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h61 + ({4'h0, v} - 8'd10));
  endfunction

  task automatic emit_cell(input int unsigned pos, input logic blank, input logic [7:0] b);
    step_text.push_back(hdlf_pkg::CH_SPACE);
    if (pos == hdlf_pkg::HALF_POS) step_text.push_back(hdlf_pkg::CH_SPACE);
    if (blank) begin
      step_text.push_back(hdlf_pkg::CH_SPACE);
      step_text.push_back(hdlf_pkg::CH_SPACE);
    end else begin
      step_text.push_back(nibble_char(b[7:4]));
      step_text.push_back(nibble_char(b[3:0]));
    end
  endtask

  task automatic emit_trailer();
    logic [7:0] c;
    step_text.push_back(hdlf_pkg::CH_SPACE);
    step_text.push_back(hdlf_pkg::CH_SPACE);
    step_text.push_back(hdlf_pkg::CH_BAR);
    for (int unsigned i = 0; i < hdlf_pkg::LINE_BYTES; i++) begin
      c = fmt_line[i];
      step_text.push_back((c >= 8'h20 && c <= 8'h7e) ? c : hdlf_pkg::CH_DOT);
    end
    step_text.push_back(hdlf_pkg::CH_BAR);
    step_text.push_back(hdlf_pkg::CH_NL);
  endtask

  task automatic restart_stream();
    fmt_pos     = 0;
    fmt_skipped = '0;
    fmt_dumped  = '0;
    fmt_addr    = fmt_skip;
  endtask

  // works out the text of one request and queues it as packed words
  task automatic format_request(input logic act, input logic [7:0] b);
    int unsigned n;
    text_word_t  w;
    step_text.delete();
    if (act == ACT_END) begin
      if (fmt_pos != 0) begin
        for (int unsigned p = fmt_pos; p < hdlf_pkg::LINE_BYTES; p++) begin
          fmt_line[p] = hdlf_pkg::CH_SPACE;
          emit_cell(p, 1'b1, 8'h00);
        end
        emit_trailer();
      end
      restart_stream();
    end else if (fmt_skipped < fmt_skip) begin
      fmt_skipped++;
    end else if (fmt_limit == 0 || fmt_dumped < fmt_limit) begin
      if (fmt_pos == 0) begin
        for (int s = 28; s >= 0; s -= 4) step_text.push_back(nibble_char(fmt_addr[s+:4]));
        step_text.push_back(hdlf_pkg::CH_SPACE);
      end
      emit_cell(fmt_pos, 1'b0, b);
      fmt_line[fmt_pos] = b;
      if (fmt_pos == hdlf_pkg::LINE_BYTES - 1) begin
        emit_trailer();
        fmt_pos = 0;
      end else begin
        fmt_pos++;
      end
      fmt_addr++;
      if (fmt_dumped != '1) fmt_dumped++;
    end
    for (int unsigned k = 0; k < step_text.size(); k += 4) begin
      n = step_text.size() - k;
      if (n > 4) n = 4;
      w.c0    = step_text[k];
      w.c1    = (n > 1) ? step_text[k+1] : 8'h00;
      w.c2    = (n > 2) ? step_text[k+2] : 8'h00;
      w.c3    = (n > 3) ? step_text[k+3] : 8'h00;
      w.count = n[2:0];
      w.last  = (k + 4 >= step_text.size());
      text_expected.push_back(w);
    end
    if (step_text.size() != 0) text_requests++;
  endtask

  // sender: bursts of random length separated by random gaps, some of zero length
  task automatic send_request(input logic act, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_bus.valid     <= 1'b1;
    in_bus.action    <= act;
    in_bus.data_byte <= b;
    @(posedge clk_i);
    while (in_bus.ready !== 1'b1) @(posedge clk_i);
    burst_left--;
    requests_sent++;
    format_request(act, b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_request(ACT_BYTE, b);
  endtask

  task automatic send_end();
    send_request(ACT_END, 8'($urandom_range(0, 255)));
  endtask

  // lets all queued text drain, plus slack for requests that make no text
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (text_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic update_register(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] seen;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    // read back the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    seen = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
    if (addr == ADDR_SKIP) begin
      fmt_skip = value;
      fmt_addr = value;
    end else begin
      fmt_limit = value;
    end
    if (seen !== value) begin
      text_errors++;
      $display("%0t: register read at %h, expected %h, actual %h", $time, addr, value, seen);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      text_errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_text
    text_word_t want;
    if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (text_expected.size() == 0) begin
        text_errors++;
        $display("%0t: unexpected text word, expected none, actual %h %h %h %h count %0d last %0b",
                 $time, out_bus.char0, out_bus.char1, out_bus.char2, out_bus.char3,
                 out_bus.char_count, out_bus.last);
      end else begin
        want = text_expected.pop_front();
        check_field("char0", want.c0, out_bus.char0);
        check_field("char1", want.c1, out_bus.char1);
        check_field("char2", want.c2, out_bus.char2);
        check_field("char3", want.c3, out_bus.char3);
        check_field("char_count", {5'd0, want.count}, {5'd0, out_bus.char_count});
        check_field("last", {7'd0, want.last}, {7'd0, out_bus.last});
        words_checked++;
      end
    end
  end

  // receiver: ready pattern changes mode at random, and holds low on a hold request
  initial begin
    int unsigned mode;
    int unsigned left;
    int unsigned hold;
    out_bus.ready <= 1'b0;
    mode = 0;
    left = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold = HOLD_CYCLES;
        holds_done++;
      end
      if (hold != 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 60);
        end
        left--;
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 3) != 0);
          2: out_bus.ready <= 1'($urandom_range(0, 1));
          default: out_bus.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) || psel === 1'b1) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: timeout, nothing moved for %0d cycles", $time, IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic test_full_line();
    logic [7:0] line_bytes [16] = '{8'h00, 8'hff, 8'h1f, 8'h20, 8'h7e, 8'h7f, 8'h80, 8'h41,
                                   8'h7a, 8'h30, 8'h39, 8'h0a, 8'h5c, 8'ha5, 8'h5a, 8'h7c};
    update_register(ADDR_SKIP, 32'd0);
    update_register(ADDR_LIMIT, 32'd0);
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
    // end right after a full line: nothing to pad
    send_end();
  endtask

  task automatic test_skip_limit_pad();
    update_register(ADDR_SKIP, 32'd5);
    update_register(ADDR_LIMIT, 32'd8);
    // five skipped, eight dumped, two past the limit, pad starts at the half
    repeat (15) send_byte(8'($urandom_range(0, 255)));
    send_end();
  endtask

  task automatic test_register_extremes();
    update_register(ADDR_SKIP, 32'hffff_ffff);
    update_register(ADDR_LIMIT, 32'hffff_ffff);
    repeat (2) send_byte(8'($urandom_range(0, 255)));
    send_end();
    update_register(ADDR_SKIP, 32'd0);
    update_register(ADDR_LIMIT, 32'd1);
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    send_end();
  endtask

  task automatic test_input_stall();
    update_register(ADDR_SKIP, 32'h0000_001b);
    update_register(ADDR_LIMIT, 32'd0);
    repeat (32'h1b) send_byte(8'($urandom_range(0, 255)));
    hold_request = 1'b1;
    repeat (40) send_byte(8'($urandom_range(0, 255)));
    send_end();
  endtask

  task automatic test_random_streams();
    int unsigned streams;
    int unsigned len;
    int unsigned pick;
    while (requests_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) update_register(ADDR_SKIP, 32'd0);
        else if (pick < 17) update_register(ADDR_SKIP, $urandom_range(1, 24));
        else if (pick < 19) update_register(ADDR_SKIP, $urandom_range(8'h40, 8'hff));
        else update_register(ADDR_SKIP, $urandom);
      end
      if ($urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, 19);
        if (pick < 11) update_register(ADDR_LIMIT, 32'd0);
        else if (pick < 16) update_register(ADDR_LIMIT, $urandom_range(1, 48));
        else if (pick < 18) update_register(ADDR_LIMIT, 32'hffff_ffff);
        else update_register(ADDR_LIMIT, $urandom);
      end
      streams = $urandom_range(1, 3);
      repeat (streams) begin
        if (requests_sent < TOTAL_ITEMS) begin
          // stray end now and then, usually on an empty line
          if ($urandom_range(0, 19) == 0) send_end();
          len = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 40) : $urandom_range(41, 90);
          if (requests_sent + len > TOTAL_ITEMS) len = TOTAL_ITEMS - requests_sent;
          repeat (len) begin
            if ($urandom_range(0, 1) != 0) send_byte(8'($urandom_range(8'h20, 8'h7e)));
            else send_byte(8'($urandom_range(0, 255)));
          end
          // some streams run on into the next stream or register setting
          if ($urandom_range(0, 9) != 0) send_end();
        end
      end
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.action    <= ACT_BYTE;
    in_bus.data_byte <= '0;
    text_errors   = 0;
    words_checked = 0;
    requests_sent = 0;
    text_requests = 0;
    reg_writes    = 0;
    holds_done    = 0;
    burst_left    = 0;
    hold_request  = 1'b0;
    fmt_skip      = '0;
    fmt_limit     = '0;
    foreach (fmt_line[i]) fmt_line[i] = 8'h00;
    restart_stream();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_line();
    test_skip_limit_pad();
    test_register_extremes();
    test_input_stall();
    test_random_streams();
    wait_idle();

    $display("run covered %0d requests, %0d of them made text, %0d text words checked",
             requests_sent, text_requests, words_checked);
    $display("register writes: %0d, long receiver hold-offs: %0d, errors: %0d",
             reg_writes, holds_done, text_errors);
    if (text_errors == 0 && text_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/hdlf_pkg.sv
hw/rtl/hdlf_if.sv
hw/rtl/hdlf_apb_regs.sv
hw/rtl/hdlf_line_mem.sv
hw/rtl/hdlf_fmt.sv
hw/rtl/hex_dump_line_formatter.sv
sim/hex_dump_line_formatter_tb.sv
